/* rtl/fir_lp_pkg.sv */
// ----------------------------------------------------------------------------
// fir_lp_pkg
// Shared types, constants and microcode word layout for the FIR low-pass.
// ----------------------------------------------------------------------------
package fir_lp_pkg;

  localparam int TAPS_DEF = 29;
  localparam int DATA_W   = 16;
  localparam int IDX_W    = 5;
  localparam int OUT_W    = 20;
  localparam int SHIFT_W  = 5;
  localparam int STEP_W   = 3;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd14;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_sample;
    logic                    saturated;
  } out_item_t;

  // Sequencer steps. LOAD and PUSH sit next to each other: dispatch adds op.
  typedef enum logic [STEP_W-1:0] {
    ST_FETCH  = 3'd0,
    ST_LOAD   = 3'd1,
    ST_PUSH   = 3'd2,
    ST_MAC    = 3'd3,
    ST_DRAIN1 = 3'd4,
    ST_DRAIN2 = 3'd5,
    ST_SHIFT  = 3'd6,
    ST_EMIT   = 3'd7
  } step_e;

  // Jump conditions; a false condition holds the current step.
  typedef enum logic [1:0] {
    JC_ALWAYS   = 2'd0,
    JC_DISPATCH = 2'd1,
    JC_TAP_LAST = 2'd2,
    JC_OUT_FREE = 2'd3
  } jc_e;

  typedef struct packed {
    logic in_rdy;
    logic coef_wr;
    logic push;
    logic mac;
    logic shift;
    logic emit;
  } ctl_t;

  typedef struct packed {
    ctl_t  ctl;
    jc_e   jc;
    step_e jt;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic op;
    logic tap_last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/fir_lp_ucode.sv */
// ----------------------------------------------------------------------------
// fir_lp_ucode
// Step counter and control-word ROM that sequence the FIR datapath.
// ----------------------------------------------------------------------------
module fir_lp_ucode
  import fir_lp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctl_t  ctl
);

  function automatic uword_t ucode_rom(input step_e s);
    uword_t w;
    w = '0;
    case (s)
      ST_FETCH: begin
        w.ctl.in_rdy = 1'b1;
        w.jc = JC_DISPATCH;
        w.jt = ST_LOAD;
      end
      ST_LOAD: begin
        w.ctl.coef_wr = 1'b1;
        w.jc = JC_ALWAYS;
        w.jt = ST_FETCH;
      end
      ST_PUSH: begin
        w.ctl.push = 1'b1;
        w.jc = JC_ALWAYS;
        w.jt = ST_MAC;
      end
      ST_MAC: begin
        w.ctl.mac = 1'b1;
        w.jc = JC_TAP_LAST;
        w.jt = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        w.jc = JC_ALWAYS;
        w.jt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        w.jc = JC_ALWAYS;
        w.jt = ST_SHIFT;
      end
      ST_SHIFT: begin
        w.ctl.shift = 1'b1;
        w.jc = JC_ALWAYS;
        w.jt = ST_EMIT;
      end
      ST_EMIT: begin
        w.ctl.emit = 1'b1;
        w.jc = JC_OUT_FREE;
        w.jt = ST_FETCH;
      end
      default: begin
        w.jc = JC_ALWAYS;
        w.jt = ST_FETCH;
      end
    endcase
    return w;
  endfunction

  step_e  step_r;
  step_e  step_nxt;
  uword_t uw;
  logic   go;

  // Outputs: control word of the current step.
  always_comb begin
    uw  = ucode_rom(step_r);
    ctl = uw.ctl;
  end

  // Next step: jump when the condition holds, otherwise hold.
  always_comb begin
    case (uw.jc)
      JC_ALWAYS:   go = 1'b1;
      JC_DISPATCH: go = stat.accept;
      JC_TAP_LAST: go = stat.tap_last;
      JC_OUT_FREE: go = stat.out_free;
      default:     go = 1'b1;
    endcase
    if (!go) begin
      step_nxt = step_r;
    end else if (uw.jc == JC_DISPATCH) begin
      step_nxt = step_e'(uw.jt + {{(STEP_W-1){1'b0}}, stat.op});
    end else begin
      step_nxt = uw.jt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/fir_lp_datapath.sv */
// ----------------------------------------------------------------------------
// fir_lp_datapath
// Coefficient and delay memories, shared MAC, shift/saturate, output register.
// ----------------------------------------------------------------------------
module fir_lp_datapath
  import fir_lp_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  output stat_t              stat,
  input  logic               in_valid,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata
);

  localparam int ADDR_W = $clog2(TAPS);
  localparam int CNT_W  = $clog2(TAPS + 1);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAPS - 1);

  logic signed [DATA_W-1:0] delay_mem [TAPS];
  logic signed [DATA_W-1:0] coef_mem  [TAPS];
  logic [TAPS-1:0]          coef_vld_r;

  in_item_t                 item_r;
  logic [SHIFT_W-1:0]       shift_r;
  logic [ADDR_W-1:0]        wp_r;
  logic [ADDR_W-1:0]        slot_r;
  logic [ADDR_W-1:0]        tap_r;
  logic [CNT_W-1:0]         seen_r;
  logic                     emit_r;
  logic signed [DATA_W-1:0] dly_q_r;
  logic signed [DATA_W-1:0] coef_q_r;
  logic                     cvld_q_r;
  logic                     rd_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  shf_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic                     accept;
  logic                     load_ok;
  logic                     out_free;
  logic                     out_wr;
  logic [ACC_W-OUT_W:0]     hi_bits;
  logic                     ovf;
  out_item_t                sat_item;
  logic signed [DATA_W-1:0] coef_eff;

  assign accept   = in_valid && ctl.in_rdy;
  assign load_ok  = int'(item_r.coef_index) < TAPS;
  assign out_free = !out_valid_r || out_ready;
  assign out_wr   = ctl.emit && emit_r && out_free;

  assign stat.accept   = accept;
  assign stat.op       = in_data.op;
  assign stat.tap_last = (tap_r == LAST_ADDR);
  assign stat.out_free = !emit_r || out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Memories.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      delay_mem[wp_r] <= item_r.value;
    end
    if (ctl.mac) begin
      dly_q_r <= delay_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.coef_wr && load_ok) begin
      coef_mem[ADDR_W'(item_r.coef_index)] <= item_r.value;
    end
    if (ctl.mac) begin
      coef_q_r <= coef_mem[tap_r];
      cvld_q_r <= coef_vld_r[tap_r];
    end
  end

  // Never-written coefficients read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (ctl.coef_wr && load_ok) begin
      coef_vld_r[ADDR_W'(item_r.coef_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RST;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  // Pointers and warm-up count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      slot_r <= '0;
      tap_r  <= '0;
      seen_r <= '0;
      emit_r <= 1'b0;
    end else if (ctl.push) begin
      wp_r   <= (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
      slot_r <= wp_r;
      tap_r  <= '0;
      emit_r <= (seen_r == CNT_W'(TAPS));
      if (seen_r != CNT_W'(TAPS)) begin
        seen_r <= seen_r + 1'b1;
      end
    end else if (ctl.mac) begin
      slot_r <= (slot_r == '0) ? LAST_ADDR : slot_r - 1'b1;
      if (tap_r != LAST_ADDR) begin
        tap_r <= tap_r + 1'b1;
      end
    end
  end

  // MAC pipeline: read, multiply, accumulate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= ctl.mac;
      prod_vld_r <= rd_vld_r;
    end
  end

  assign coef_eff = cvld_q_r ? coef_q_r : '0;

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prod_r <= dly_q_r * coef_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      shf_r <= acc_r >>> shift_r;
    end
  end

  // Saturate: clip when the result's sign bit and the bits above it disagree.
  always_comb begin
    hi_bits  = shf_r[ACC_W-1:OUT_W-1];
    ovf      = !((&hi_bits) || !(|hi_bits));
    sat_item.saturated = ovf;
    if (ovf) begin
      sat_item.out_sample = shf_r[ACC_W-1] ? OUT_MIN : OUT_MAX;
    end else begin
      sat_item.out_sample = shf_r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr) begin
      out_r <= sat_item;
    end
  end

endmodule

/* rtl/fir_lowpass_filter.sv */
// ----------------------------------------------------------------------------
// fir_lowpass_filter
// Samples are processed one at a time: one shared MAC walks every tap, and no
// new item is taken until the sequencer has finished the previous one.
// Reset: synchronous, active low; clears coefficients (valid bits), the delay
// line pointers and warm-up count, result_shift returns to 14.
// ----------------------------------------------------------------------------
module fir_lowpass_filter
  import fir_lp_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata
);

  // Control word from the microcode ROM and status back from the datapath.
  ctl_t  ctl;
  stat_t stat;

  // The sequencer only takes an item in its fetch step. A load finishes in
  // the next step; a sample runs push, TAPS MAC steps, two drain steps for
  // the read and multiply registers, shift, then emit. Emit holds while the
  // output register still carries an untaken result, so no result is lost.
  assign in_ready = ctl.in_rdy;

  fir_lp_ucode u_ucode (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Datapath: coefficient table with per-entry valid bits (unwritten entries
  // read as zero), circular delay line, MAC pipeline, floor shift by
  // result_shift and saturation to 20 bits into the output register.
  fir_lp_datapath #(
    .TAPS (TAPS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

`ifndef SYNTH
  // After taking an item the sequencer leaves fetch at once.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  // A new result appears only out of the emit step.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctl.emit))
    else $error("result raised outside emit step");

  // A clipped result sits on a rail.
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.out_sample == OUT_MAX || out_data.out_sample == OUT_MIN))
    else $error("saturated flag without rail value");

  // The MAC never runs while the sequencer can take an item or emits.
  a_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mac |-> !in_ready && !ctl.emit)
    else $error("MAC step overlaps fetch or emit");
`endif

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: fir_lowpass_filter testbench
// Streams coefficient loads and samples into the filter and compares every
// filtered sample against a behavioral convolution kept in the testbench.
// A directed opening warms up the delay line and covers the field extremes.
// Random phases follow, each under its own result_shift.
// ----------------------------------------------------------------------------
module tb_top;
  import fir_lp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS           = TAPS_DEF;
  localparam int IDLE_PCT       = 27;
  localparam int ITEMS_PER_PASS = 150;
  localparam int STALL_LIMIT    = 2000;
  localparam int REPORT_MAX     = 10;

  // Input item opcodes (op field).
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [SHIFT_W-1:0] cfg_wdata = '0;

  // Items waiting for the driver, and filtered samples still owed by the DUT.
  in_item_t  item_backlog[$];
  out_item_t owed_samples[$];

  // Shadow of the filter state, updated as items are accepted.
  logic signed [DATA_W-1:0] tap_history[TAPS];
  logic signed [DATA_W-1:0] coef_shadow[TAPS];
  int                       next_slot;
  int                       pushed_count;
  logic [SHIFT_W-1:0]       shift_shadow;

  int  mismatches   = 0;
  int  quiet_cycles = 0;
  // Suppress random idling on both channels while set.
  logic steady = 1'b0;

  fir_lowpass_filter #(.TAPS(TAPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Advance the shadow filter by one accepted item; queue the filtered
  // sample if the item produces one.
  function automatic void compute_filter_output(input in_item_t item);
    longint    acc;
    longint    scaled;
    int        slot;
    logic      warm;
    out_item_t res;
    if (item.op == OP_LOAD) begin
      // Drop loads that point past the table.
      if (int'(item.coef_index) < TAPS) begin
        coef_shadow[item.coef_index] = item.value;
      end
      return;
    end
    warm = (pushed_count >= TAPS);
    tap_history[next_slot] = item.value;
    acc = 0;
    for (int i = 0; i < TAPS; i++) begin
      slot = (next_slot + TAPS - i) % TAPS;
      acc += longint'(tap_history[slot]) * longint'(coef_shadow[i]);
    end
    next_slot = (next_slot + 1) % TAPS;
    if (pushed_count < TAPS) begin
      pushed_count++;
    end
    // Warm-up samples fill the history but give no output.
    if (!warm) begin
      return;
    end
    // Arithmetic shift floors toward minus infinity, then clip to 20 bits.
    scaled = acc >>> shift_shadow;
    res.saturated = 1'b0;
    if (scaled > longint'(OUT_MAX)) begin
      scaled = longint'(OUT_MAX);
      res.saturated = 1'b1;
    end else if (scaled < longint'(OUT_MIN)) begin
      scaled = longint'(OUT_MIN);
      res.saturated = 1'b1;
    end
    res.out_sample = scaled[OUT_W-1:0];
    owed_samples.push_back(res);
  endfunction

  // Bias toward full-scale and near-zero values; the rest is uniform.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3, 4:    return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_item(input logic op, input logic [IDX_W-1:0] idx,
                                     input logic signed [DATA_W-1:0] val);
    in_item_t item;
    item.op         = op;
    item.coef_index = idx;
    item.value      = val;
    item_backlog.push_back(item);
  endfunction

  // Mostly samples; loads mostly hit the table, some land past its end.
  function automatic void queue_random_item();
    if ($urandom_range(0, 99) < 80) begin
      queue_item(OP_PUSH, IDX_W'($urandom), pick_value());
    end else if ($urandom_range(0, 9) == 0) begin
      queue_item(OP_LOAD, IDX_W'($urandom_range(TAPS, 31)), pick_value());
    end else begin
      queue_item(OP_LOAD, IDX_W'($urandom_range(0, TAPS - 1)), pick_value());
    end
  endfunction

  // Hold the sender until every owed sample has come back, then give the
  // sequencer time to finish any trailing load.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (item_backlog.size() != 0 || in_valid || owed_samples.size() != 0);
    repeat (TAPS + 10) @(negedge clk);
  endtask

  // Write result_shift while the filter is idle.
  task automatic set_result_shift(input logic [SHIFT_W-1:0] s);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shift_shadow = s;
    @(negedge clk);
  endtask

  // Driver: hold the item until accepted, then advance to the next one or
  // idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        compute_filter_output(in_data);
      end
      if (!in_valid || in_ready) begin
        if (item_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= item_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted output against the oldest owed sample.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_samples.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("unexpected output: sample %0d sat %0b",
                     out_data.out_sample, out_data.saturated);
          end
          mismatches++;
        end else begin
          want = owed_samples.pop_front();
          if (out_data.out_sample !== want.out_sample ||
              out_data.saturated !== want.saturated) begin
            if (mismatches < REPORT_MAX) begin
              $display("mismatch: expected sample %0d sat %0b, got sample %0d sat %0b",
                       want.out_sample, want.saturated,
                       out_data.out_sample, out_data.saturated);
            end
            mismatches++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("fir_lowpass_filter verification failed");
      $finish;
    end
  end

  initial begin
    logic [SHIFT_W-1:0] pass_shift[9];
    for (int i = 0; i < TAPS; i++) begin
      tap_history[i] = '0;
      coef_shadow[i] = '0;
    end
    next_slot    = 0;
    pushed_count = 0;
    shift_shadow = SHIFT_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening under the reset shift.
    // Loads past the table end must leave the coefficients alone.
    queue_item(OP_LOAD, IDX_W'(TAPS), 16'sh7FFF);
    queue_item(OP_LOAD, 5'd30, 16'sh8000);
    queue_item(OP_LOAD, 5'd31, 16'sh7FFF);
    // Full-scale coefficients at the start of the table, others inside and at its end.
    queue_item(OP_LOAD, 5'd0, 16'sh7FFF);
    queue_item(OP_LOAD, 5'd1, 16'sh8000);
    queue_item(OP_LOAD, 5'd2, 16'sh0001);
    queue_item(OP_LOAD, 5'd14, 16'sh4000);
    queue_item(OP_LOAD, IDX_W'(TAPS - 1), 16'shFFFF);
    // Warm-up: fill the history with no output expected.
    for (int i = 0; i < TAPS; i++) begin
      queue_item(OP_PUSH, IDX_W'(i), (i % 2 == 0) ? 16'sh7FFF : 16'sh8000);
    end
    // First outputs, then a coefficient change mid-stream.
    queue_item(OP_PUSH, 5'd31, 16'sh7FFF);
    queue_item(OP_PUSH, 5'd0, 16'sh8000);
    queue_item(OP_PUSH, 5'd0, 16'sh0000);
    queue_item(OP_PUSH, 5'd0, 16'shFFFF);
    queue_item(OP_LOAD, 5'd5, 16'shCFC7);
    queue_item(OP_PUSH, 5'd0, 16'sh0001);
    queue_item(OP_PUSH, 5'd0, 16'sh7FFF);
    // Pause the sender until all owed samples are back.
    wait_drained();

    // Random phases; include both shift extremes, hold one phase steady.
    pass_shift = '{5'd0, 5'd31, 5'd9, 5'd14, SHIFT_W'($urandom), 5'd3, 5'd20,
                   SHIFT_W'($urandom), 5'd1};
    foreach (pass_shift[p]) begin
      set_result_shift(pass_shift[p]);
      steady = (p == 2);
      for (int n = 0; n < ITEMS_PER_PASS; n++) begin
        queue_random_item();
      end
      wait_drained();
    end
    steady = 1'b0;

    if (mismatches == 0 && owed_samples.size() == 0) begin
      $display("fir_lowpass_filter verification clean");
    end else begin
      $display("fir_lowpass_filter verification failed");
    end
    $finish;
  end

endmodule
